>>> src/bfdh_pkg.sv
// Shared types, constants and the control store for the double-hashing Bloom filter.
// Used by bloom_filter_double_hash_top; it depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bfdh_pkg;

    // Filter geometry.
    localparam int unsigned MAX_BITS   = 65536;
    localparam int unsigned MAX_PROBES = 16;
    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned WORD_COUNT = MAX_BITS / WORD_BITS;
    localparam int unsigned IDX_W      = $clog2(MAX_BITS);
    localparam int unsigned MOD_W      = IDX_W + 1;
    localparam int unsigned BIT_W      = $clog2(WORD_BITS);
    localparam int unsigned WADDR_W    = $clog2(WORD_COUNT);

    // Field widths.
    localparam int unsigned HASH_W     = 64;
    localparam int unsigned HALF_W     = HASH_W / 2;
    localparam int unsigned HALF_IDX_W = $clog2(HALF_W);
    localparam int unsigned BITS_CFG_W = 17;
    localparam int unsigned PRB_W      = 5;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 17;

    // The remainder unit retires two dividend bits per step.
    localparam int unsigned DIV_STEPS  = HALF_W / 2;
    localparam int unsigned PAIR_W     = $clog2(DIV_STEPS);

    localparam int unsigned CNT_MAX_A  = (WORD_COUNT > MAX_PROBES) ? WORD_COUNT : MAX_PROBES;
    localparam int unsigned CNT_MAX    = (CNT_MAX_A > DIV_STEPS) ? CNT_MAX_A : DIV_STEPS;
    localparam int unsigned CNT_W      = $clog2(CNT_MAX + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BITS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = CFG_IDX_W'(1);

    localparam logic [BITS_CFG_W-1:0] BITS_RESET   = BITS_CFG_W'(65536);
    localparam logic [PRB_W-1:0]      PROBES_RESET = PRB_W'(7);

    // Opcodes of an input beat.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Control store addresses.
    localparam int unsigned UA_W = 3;
    localparam logic [UA_W-1:0] UA_CLEAR  = UA_W'(0);
    localparam logic [UA_W-1:0] UA_IDLE   = UA_W'(1);
    localparam logic [UA_W-1:0] UA_DIV    = UA_W'(2);
    localparam logic [UA_W-1:0] UA_SETUP1 = UA_W'(3);
    localparam logic [UA_W-1:0] UA_SETUP2 = UA_W'(4);
    localparam logic [UA_W-1:0] UA_READ   = UA_W'(5);
    localparam logic [UA_W-1:0] UA_CHECK  = UA_W'(6);
    localparam logic [UA_W-1:0] UA_EMIT   = UA_W'(7);

    // Datapath operation of one step.
    typedef enum logic [2:0] {
        DP_CLEAR,
        DP_LOAD,
        DP_DIV,
        DP_CMOD,
        DP_SETUP,
        DP_READ,
        DP_CHECK,
        DP_EMIT
    } dp_op_t;

    // How the step counter moves on.
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_WAIT_IN,
        SEQ_SKIP_ZERO,
        SEQ_MORE,
        SEQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        dp_op_t          op;
        seq_t            seq;
        logic [UA_W-1:0] target;
    } uword_t;

    function automatic uword_t ucode_rom(input logic [UA_W-1:0] addr);
        uword_t w;
        begin
            unique case (addr)
                UA_CLEAR:  w = '{op: DP_CLEAR, seq: SEQ_LOOP,      target: UA_CLEAR};
                UA_IDLE:   w = '{op: DP_LOAD,  seq: SEQ_WAIT_IN,   target: UA_IDLE};
                UA_DIV:    w = '{op: DP_DIV,   seq: SEQ_LOOP,      target: UA_DIV};
                UA_SETUP1: w = '{op: DP_CMOD,  seq: SEQ_NEXT,      target: UA_IDLE};
                UA_SETUP2: w = '{op: DP_SETUP, seq: SEQ_SKIP_ZERO, target: UA_EMIT};
                UA_READ:   w = '{op: DP_READ,  seq: SEQ_NEXT,      target: UA_IDLE};
                UA_CHECK:  w = '{op: DP_CHECK, seq: SEQ_MORE,      target: UA_READ};
                UA_EMIT:   w = '{op: DP_EMIT,  seq: SEQ_WAIT_OUT,  target: UA_IDLE};
                default:   w = '{op: DP_EMIT,  seq: SEQ_WAIT_OUT,  target: UA_IDLE};
            endcase
            return w;
        end
    endfunction

    // One restoring remainder step: shift in one dividend bit, subtract the modulus if it fits.
    function automatic logic [IDX_W-1:0] rem_step(input logic [IDX_W-1:0] r,
                                                   input logic             b,
                                                   input logic [MOD_W-1:0] m);
        logic [MOD_W-1:0] t;
        begin
            t = {r, b};
            if (t >= m)
            begin
                t = t - m;
            end
            return t[IDX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> src/bfdh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the filter words of the Bloom filter.
`timescale 1ns / 1ps
`default_nettype none

module bfdh_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/bloom_filter_double_hash_top.sv
// Top level of the double-hashing Bloom filter: microcoded control, remainder lanes,
// probe datapath and handshakes. Depends on bfdh_pkg and bfdh_ram.
`timescale 1ns / 1ps
`default_nettype none

// Bloom filter over a 65536-bit store kept as 1024 words of 64 bits. After reset the block
// clears the store one word per cycle and takes no input beat meanwhile; configuration
// writes are taken at any time. An input beat carries an opcode (insert or query) and a
// 64-bit hash whose halves L and H give probe indices ((L + i*H) mod 2^32) mod m. The block
// takes no new item until it is through with the last; a query stops at the first clear bit.
// The remainder unit reduces L, H and 2^32 modulo m two bits per cycle, and each probe is a
// read step and then a check step, which for an insert writes the word back with its bit set.
// Later probe indices follow by one modular add each. Inserts give no output beat; a query
// gives one beat on present, held in an output register until it is taken.
module bloom_filter_double_hash_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               opcode,
    input  wire logic [bfdh_pkg::HASH_W-1:0]        hash_key,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    present,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import bfdh_pkg::*;

    // Sequencer.
    logic [UA_W-1:0]       upc_reg, upc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_m1;
    logic                  cnt_last;
    uword_t                uw;

    // Configuration.
    logic [BITS_CFG_W-1:0] bits_reg;
    logic [PRB_W-1:0]      probes_reg;
    logic [MOD_W-1:0]      m_cfg;
    logic [PRB_W-1:0]      k_cfg;

    // Datapath.
    logic                  op_reg;
    logic [HALF_W-1:0]     lo_reg, hi_reg, s_reg;
    logic [MOD_W-1:0]      mod_reg;
    logic [IDX_W-1:0]      rl_reg, rh_reg, rc_reg;
    logic [WADDR_W-1:0]    addr_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic                  hit_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  present_reg;

    logic [PAIR_W-1:0]     pair;
    logic [HALF_IDX_W-1:0] bit_hi_idx, bit_lo_idx;
    logic [IDX_W-1:0]      rl_mid, rh_mid, rc_mid;
    logic [HALF_W:0]       sum_ext;
    logic                  wrap;
    logic [IDX_W-1:0]      step_add;
    logic [MOD_W-1:0]      adv_sum;
    logic [IDX_W-1:0]      r_adv;
    logic [MOD_W-1:0]      cm_inc;
    logic [IDX_W-1:0]      cm_val;
    logic [MOD_W-1:0]      d_diff;
    logic [IDX_W-1:0]      d_val;

    logic                  in_accept;
    logic                  rd_bit;
    logic                  miss;
    logic                  emit_block;
    logic                  emit_load;

    logic                  ram_we;
    logic [WADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    assign uw        = ucode_rom(upc_reg);
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign cnt_last  = (cnt_reg == CNT_W'(1));

    assign in_stall  = (upc_reg != UA_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign present   = present_reg;

    // Registers are kept as written; the clamping happens here.
    always_comb
    begin
        if (bits_reg == '0)
        begin
            m_cfg = MOD_W'(1);
        end
        else if (bits_reg > BITS_CFG_W'(MAX_BITS))
        begin
            m_cfg = MOD_W'(MAX_BITS);
        end
        else
        begin
            m_cfg = MOD_W'(bits_reg);
        end
        k_cfg = (probes_reg > PRB_W'(MAX_PROBES)) ? PRB_W'(MAX_PROBES) : probes_reg;
    end

    // Remainder lanes for L, H and the all-ones word, two dividend bits per step, MSB first.
    assign pair       = cnt_m1[PAIR_W-1:0];
    assign bit_hi_idx = {pair, 1'b1};
    assign bit_lo_idx = {pair, 1'b0};
    assign rl_mid     = rem_step(rl_reg, lo_reg[bit_hi_idx], mod_reg);
    assign rh_mid     = rem_step(rh_reg, hi_reg[bit_hi_idx], mod_reg);
    assign rc_mid     = rem_step(rc_reg, 1'b1, mod_reg);

    // 2^32 mod m from (2^32 - 1) mod m.
    assign cm_inc = {1'b0, rc_reg} + MOD_W'(1);
    assign cm_val = (cm_inc == mod_reg) ? '0 : cm_inc[IDX_W-1:0];

    // Step used when the running sum wraps: (H - 2^32) mod m.
    always_comb
    begin
        d_diff = {1'b0, rh_reg} - {1'b0, rc_reg};
        if (rh_reg < rc_reg)
        begin
            d_diff = d_diff + mod_reg;
        end
        d_val = d_diff[IDX_W-1:0];
    end

    // The next probe residue follows from the current one by a single modular add.
    assign sum_ext  = {1'b0, s_reg} + {1'b0, hi_reg};
    assign wrap     = sum_ext[HALF_W];
    assign step_add = wrap ? rc_reg : rh_reg;
    assign adv_sum  = {1'b0, rl_reg} + {1'b0, step_add};
    assign r_adv    = (adv_sum >= mod_reg) ? IDX_W'(adv_sum - mod_reg) : adv_sum[IDX_W-1:0];

    assign rd_bit     = ram_rdata[bit_reg];
    assign miss       = (op_reg == OP_QUERY) && !rd_bit;
    assign emit_block = (op_reg == OP_QUERY) && out_valid_reg && out_stall;
    assign emit_load  = (uw.op == DP_EMIT) && (op_reg == OP_QUERY) && !emit_block;

    // Memory port.
    assign ram_raddr = rl_reg[IDX_W-1:BIT_W];
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_reg);
        if (uw.op == DP_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_m1[WADDR_W-1:0];
            ram_wdata = '0;
        end
        else if ((uw.op == DP_CHECK) && (op_reg == OP_INSERT))
        begin
            ram_we = 1'b1;
        end
    end

    bfdh_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next step address.
    always_comb
    begin
        unique case (uw.seq)
            SEQ_NEXT:      upc_next = upc_reg + UA_W'(1);
            SEQ_LOOP:      upc_next = cnt_last ? upc_reg + UA_W'(1) : uw.target;
            SEQ_WAIT_IN:   upc_next = in_accept ? upc_reg + UA_W'(1) : upc_reg;
            SEQ_SKIP_ZERO: upc_next = (k_cfg == '0) ? uw.target : upc_reg + UA_W'(1);
            SEQ_MORE:      upc_next = (!cnt_last && !miss) ? uw.target : upc_reg + UA_W'(1);
            SEQ_WAIT_OUT:  upc_next = emit_block ? upc_reg : uw.target;
            default:       upc_next = UA_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (uw.op)
            DP_CLEAR, DP_DIV, DP_CHECK: cnt_next = cnt_m1;
            DP_LOAD:                    cnt_next = in_accept ? CNT_W'(DIV_STEPS) : cnt_reg;
            DP_SETUP:                   cnt_next = CNT_W'(k_cfg);
            default:                    cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_CLEAR;
            cnt_reg       <= CNT_W'(WORD_COUNT);
            out_valid_reg <= 1'b0;
            bits_reg      <= BITS_RESET;
            probes_reg    <= PROBES_RESET;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                priority if (cfg_index == REG_BITS_IN_USE)
                begin
                    bits_reg <= cfg_data[BITS_CFG_W-1:0];
                end
                else if (cfg_index == REG_PROBE_COUNT)
                begin
                    probes_reg <= cfg_data[PRB_W-1:0];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            present_reg <= hit_reg;
        end
        unique case (uw.op)
            DP_LOAD:
            begin
                if (in_accept)
                begin
                    op_reg  <= opcode;
                    lo_reg  <= hash_key[HALF_W-1:0];
                    hi_reg  <= hash_key[HASH_W-1:HALF_W];
                    mod_reg <= m_cfg;
                    rl_reg  <= '0;
                    rh_reg  <= '0;
                    rc_reg  <= '0;
                    hit_reg <= 1'b1;
                end
            end
            DP_DIV:
            begin
                rl_reg <= rem_step(rl_mid, lo_reg[bit_lo_idx], mod_reg);
                rh_reg <= rem_step(rh_mid, hi_reg[bit_lo_idx], mod_reg);
                rc_reg <= rem_step(rc_mid, 1'b1, mod_reg);
            end
            DP_CMOD:
            begin
                rc_reg <= cm_val;
            end
            DP_SETUP:
            begin
                rc_reg <= d_val;
                s_reg  <= lo_reg;
            end
            DP_READ:
            begin
                addr_reg <= rl_reg[IDX_W-1:BIT_W];
                bit_reg  <= rl_reg[BIT_W-1:0];
                rl_reg   <= r_adv;
                s_reg    <= sum_ext[HALF_W-1:0];
            end
            DP_CHECK:
            begin
                if (miss)
                begin
                    hit_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // A query never writes the store.
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_CHECK && op_reg == OP_QUERY) |-> !ram_we)
        else $error("store written during a query probe");

    // The probe residue is always a valid bit index.
    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_READ) |-> (MOD_W'(rl_reg) < mod_reg))
        else $error("probe residue not below the modulus");

    // A result beat only appears from the emit step.
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(upc_reg == UA_EMIT))
        else $error("output beat raised outside the emit step");

    // An accepted beat always starts the remainder loop.
    a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (upc_reg == UA_DIV))
        else $error("accepted beat did not start the remainder loop");

    // The probe loop is never entered with no probes left.
    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_READ) |-> (cnt_reg != '0))
        else $error("probe loop entered with zero count");

endmodule

`default_nettype wire

>>> tb/bloom_membership_checker.sv
// Checker for the double-hashing Bloom filter: watches the input, output and register
// channels, keeps its own copy of the filter bits and compares every present beat.
// Depends on bfdh_pkg for widths, register indexes and opcodes.
`timescale 1ns / 1ps

module bloom_membership_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              opcode,
    input  logic [bfdh_pkg::HASH_W-1:0]       hash_key,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              present,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                fail_count,
    output int                                pending_count
);
    import bfdh_pkg::*;

    logic [MAX_BITS-1:0]   filter_bits;
    logic [BITS_CFG_W-1:0] bits_in_use_q;
    logic [PRB_W-1:0]      probe_count_q;
    logic                  presence_expected[$];

    // The sum wraps at 32 bits before the reduction, as the hardware does.
    function automatic logic [31:0] probe_slot(input logic [31:0] lo,
                                               input logic [31:0] hi,
                                               input int unsigned i,
                                               input logic [31:0] modulus);
        logic [31:0] sum;
        sum = lo + i * hi;
        return sum % modulus;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic        want;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] modulus;
        logic [31:0] slot;
        int unsigned probes;
        logic        hit;
        if (!rst_n)
        begin
            filter_bits   = '0;
            bits_in_use_q = BITS_RESET;
            probe_count_q = PROBES_RESET;
            presence_expected.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // Results are retired first; a query taken at this edge cannot answer yet.
            if (out_valid && !out_stall)
            begin
                if (presence_expected.size() == 0)
                begin
                    note_failure($sformatf("present=%0b with no query outstanding", present));
                end
                else
                begin
                    want = presence_expected.pop_front();
                    if (present !== want)
                    begin
                        note_failure($sformatf("present expected %0b, actual %0b",
                                               want, present));
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BITS_IN_USE)
                begin
                    bits_in_use_q = cfg_data[BITS_CFG_W-1:0];
                end
                else if (cfg_index == REG_PROBE_COUNT)
                begin
                    probe_count_q = cfg_data[PRB_W-1:0];
                end
            end

            if (in_valid && !in_stall)
            begin
                lo = hash_key[HALF_W-1:0];
                hi = hash_key[HASH_W-1:HALF_W];
                // Registers hold what was written; clamping applies only here.
                if (bits_in_use_q == '0)
                begin
                    modulus = 32'd1;
                end
                else if (bits_in_use_q > MAX_BITS)
                begin
                    modulus = MAX_BITS;
                end
                else
                begin
                    modulus = 32'(bits_in_use_q);
                end
                probes = (probe_count_q > MAX_PROBES) ? MAX_PROBES : probe_count_q;
                hit = 1'b1;
                for (int unsigned i = 0; i < probes; i++)
                begin
                    slot = probe_slot(lo, hi, i, modulus);
                    if (opcode == OP_INSERT)
                    begin
                        filter_bits[slot[IDX_W-1:0]] = 1'b1;
                    end
                    else if (!filter_bits[slot[IDX_W-1:0]])
                    begin
                        hit = 1'b0;
                    end
                end
                if (opcode == OP_QUERY)
                begin
                    presence_expected.push_back(hit);
                end
            end

            pending_count = presence_expected.size();
        end
    end

endmodule

>>> tb/tb_bloom_filter_double_hash_top.sv
// Testbench top for bloom_filter_double_hash_top: clock, reset, register writes, insert and
// query beats with random idling on both sides, and the final verdict.
// Depends on bfdh_pkg, the block itself and bloom_membership_checker.
`timescale 1ns / 1ps

module tb_bloom_filter_double_hash_top;
    import bfdh_pkg::*;

    localparam int unsigned RUN_LIMIT    = 1000000;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned POOL_DEPTH   = 48;

    // Indexes past the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_NEXT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP  = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  opcode;
    logic [HASH_W-1:0]     hash_key;
    logic                  out_valid;
    logic                  out_stall;
    logic                  present;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    bit          idling_on;
    bit          long_hold_req;
    bit          long_hold_done;
    logic [HASH_W-1:0] key_pool[$];

    bloom_filter_double_hash_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .hash_key  (hash_key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .present   (present),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bloom_membership_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .hash_key      (hash_key),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .present       (present),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: short random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [HASH_W-1:0] fresh_key();
        logic [HASH_W-1:0] key;
        key = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: key[HASH_W-1:HALF_W] = '0;   // every probe lands on the same bit
            1: key[HASH_W-1:HALF_W] = '1;
            default: ;
        endcase
        return key;
    endfunction

    // in_valid stays high from one beat to the next unless a gap is taken.
    task automatic send_item(input logic op, input logic [HASH_W-1:0] key);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        hash_key <= key;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] bits,
                              input logic [CFG_DATA_W-1:0] probes);
        write_reg(REG_BITS_IN_USE, bits);
        write_reg(REG_PROBE_COUNT, probes);
    endtask

    // Inserts answer nothing, so after the last query the block may still be busy.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly inserts of new keys and queries of keys already inserted, with some
    // one-bit-off and unseen keys mixed in.
    task automatic random_items(input int count);
        logic [HASH_W-1:0] key;
        int                pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || key_pool.size() == 0)
            begin
                key = fresh_key();
                key_pool.push_back(key);
                if (key_pool.size() > POOL_DEPTH)
                begin
                    void'(key_pool.pop_front());
                end
                send_item(OP_INSERT, key);
            end
            else if (pick < 75)
            begin
                send_item(OP_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
            end
            else if (pick < 88)
            begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                key[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
                send_item(OP_QUERY, key);
            end
            else
            begin
                send_item(OP_QUERY, fresh_key());
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_INSERT;
        hash_key      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_BITS_IN_USE;
        cfg_data      = '0;
        idling_on     = 1'b1;
        long_hold_req = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty filter, the all-zero and all-one keys, an early miss.
        send_item(OP_QUERY,  64'h0);
        send_item(OP_INSERT, 64'h0);
        send_item(OP_QUERY,  64'h0);
        send_item(OP_QUERY,  64'h00000001_00000000);
        send_item(OP_QUERY,  64'hFFFFFFFF_FFFFFFFF);
        send_item(OP_INSERT, 64'hFFFFFFFF_FFFFFFFF);
        send_item(OP_QUERY,  64'hFFFFFFFF_FFFFFFFF);
        send_item(OP_INSERT, 64'h00000000_FFFFFFFF);
        send_item(OP_QUERY,  64'h80000000_7FFFFFFF);
        send_item(OP_INSERT, 64'h12345678_9ABCDEF0);
        send_item(OP_QUERY,  64'h12345678_9ABCDEF0);
        send_item(OP_QUERY,  64'h12345678_9ABCDEF1);
        drain();

        // Zero bits in use and zero probes: inserts do nothing, queries always hit.
        set_config(17'd0, 17'd0);
        send_item(OP_INSERT, fresh_key());
        send_item(OP_QUERY,  64'h5A5AA5A5_C3C33C3C);
        drain();

        // Modulus of zero taken as one: every probe reads bit 0.
        write_reg(REG_PROBE_COUNT, 17'd3);
        send_item(OP_QUERY,  fresh_key());
        send_item(OP_INSERT, fresh_key());
        drain();

        // Both registers above their limits, and writes outside the register map.
        set_config(17'h1FFFF, 17'd31);
        write_reg(REG_UNMAPPED_NEXT, 17'd5);
        write_reg(REG_UNMAPPED_TOP, 17'h1FFFF);
        send_item(OP_INSERT, 64'hFFFFFFFF_00000000);
        send_item(OP_QUERY,  64'hFFFFFFFF_00000000);
        send_item(OP_QUERY,  64'hFFFFFFFF_FFFFFFFF);
        send_item(OP_QUERY,  64'h00010000_00000001);
        send_item(OP_INSERT, 64'h0);
        drain();

        // Hold results back long enough for the block to fill and stall its input.
        set_config(17'd65536, 17'd16);
        long_hold_req = 1'b1;
        repeat (24) send_item(OP_QUERY, fresh_key());
        random_items(90);
        drain();

        set_config(17'd1, 17'd1);
        random_items(110);
        drain();

        set_config(17'd64, 17'd4);
        random_items(110);
        drain();

        set_config(17'd4096, 17'd7);
        random_items(110);
        drain();

        set_config(CFG_DATA_W'($urandom_range(1, 65536)), CFG_DATA_W'($urandom_range(1, 16)));
        random_items(110);
        drain();

        set_config(CFG_DATA_W'($urandom_range(0, 131071)), CFG_DATA_W'($urandom_range(0, 31)));
        random_items(110);
        drain();

        // Closing stretch at full rate on both sides.
        idling_on = 1'b0;
        set_config(17'd65536, 17'd7);
        random_items(110);
        drain();

        if (fail_count == 0 && pending_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
